FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while rst_n is low.
`define LQAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define LQAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LQAM_ASSERT(lbl, prop, msg)
`define LQAM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/lqam_pkg.sv
// ----------------------------------------------------------------------------
// Link quality alert monitor package
// Shared types and constants of the monitor core.
// ----------------------------------------------------------------------------
`default_nettype none

package lqam_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic signed [7:0] GOOD_THR_RST  = -8'sd60;
  localparam logic signed [7:0] WEAK_THR_RST  = -8'sd75;
  localparam logic [47:0]       ALERT_IVL_RST = 48'd10000000;
  localparam logic [7:0]        OUTAGE_CNT_RST = 8'd3;

  // Whole seconds: drop six bits (division by 64), then multiply by the
  // rounded-up reciprocal of 15625 scaled by 2^56. Exact for 42-bit inputs.
  localparam int unsigned DIVIDEND_W = 42;
  localparam int unsigned SECS_W     = 29;
  localparam int unsigned RECIP_LO_W = 22;
  localparam int unsigned SEC_SHIFT  = 56;
  localparam logic [42:0] SEC_RECIP    = 43'd4611686018428;
  localparam logic [21:0] SEC_RECIP_LO = SEC_RECIP[21:0];
  localparam logic [20:0] SEC_RECIP_HI = SEC_RECIP[42:22];

  typedef enum logic [2:0] {
    EV_DISCONNECTED      = 3'd0,
    EV_RECONNECTED       = 3'd1,
    EV_ROAM              = 3'd2,
    EV_WEAK              = 3'd3,
    EV_OUTAGE_START      = 3'd4,
    EV_RECOVERED         = 3'd5,
    EV_RECOVERED_OUTAGE  = 3'd6
  } ev_kind_t;

  typedef struct packed {
    logic signed [7:0] good_thr;
    logic signed [7:0] weak_thr;
    logic [47:0]       alert_ivl;
    logic [7:0]        outage_cnt;
  } cfg_t;

  typedef struct packed {
    logic              connected;
    logic signed [7:0] rssi;
    logic [47:0]       ap_id;
    logic [47:0]       timestamp_us;
  } sample_t;

  // Everything one sample gives, up to three events in order.
  typedef struct packed {
    logic [1:0]              cnt;
    ev_kind_t [2:0]          kind;
    logic signed [7:0]       rssi;
    logic [7:0]              count;
    logic [47:0]             old_id;
    logic [47:0]             new_id;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [SECS_W-1:0]       secs;
  } evset_t;

  typedef struct packed {
    ev_kind_t          event_kind;
    logic signed [7:0] event_rssi;
    logic [7:0]        alert_count;
    logic [SECS_W-1:0] outage_secs;
    logic [47:0]       old_ap_id;
    logic [47:0]       new_ap_id;
    logic              last;
  } event_t;

endpackage

`default_nettype wire

FILE: sv/lqam_regs.sv
// ----------------------------------------------------------------------------
// Link quality alert monitor registers
// APB register file holding thresholds, alert interval and outage count.
// ----------------------------------------------------------------------------
`default_nettype none

module lqam_regs import lqam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  typedef enum logic [1:0] {
    REG_GOOD_THR   = 2'd0,
    REG_WEAK_THR   = 2'd1,
    REG_ALERT_IVL  = 2'd2,
    REG_OUTAGE_CNT = 2'd3
  } reg_idx_t;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.good_thr   <= GOOD_THR_RST;
      cfg_r.weak_thr   <= WEAK_THR_RST;
      cfg_r.alert_ivl  <= ALERT_IVL_RST;
      cfg_r.outage_cnt <= OUTAGE_CNT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GOOD_THR:   cfg_r.good_thr   <= pwdata[7:0];
        REG_WEAK_THR:   cfg_r.weak_thr   <= pwdata[7:0];
        REG_ALERT_IVL:  cfg_r.alert_ivl  <= pwdata[47:0];
        REG_OUTAGE_CNT: cfg_r.outage_cnt <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GOOD_THR:   prdata = {56'd0, cfg_r.good_thr};
      REG_WEAK_THR:   prdata = {56'd0, cfg_r.weak_thr};
      REG_ALERT_IVL:  prdata = {16'd0, cfg_r.alert_ivl};
      REG_OUTAGE_CNT: prdata = {56'd0, cfg_r.outage_cnt};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/lqam_eval.sv
// ----------------------------------------------------------------------------
// Link quality alert monitor evaluation stage
// Input register, link/roam/quality state and the registered event set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lqam_eval import lqam_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    smp_valid,
  output logic    smp_ready,
  input  sample_t smp,
  output logic    ev_valid,
  input  logic    ev_ready,
  output evset_t  ev
);

  typedef enum logic [1:0] {
    Q_GOOD   = 2'd0,
    Q_WEAK   = 2'd1,
    Q_OUTAGE = 2'd2
  } quality_t;

  sample_t     s0_r;
  logic        s0_v_r;
  quality_t    q_r, q_nxt;
  logic [7:0]  weak_r, weak_nxt;
  logic [47:0] last_alert_r, last_alert_nxt;
  logic [47:0] out_start_r, out_start_nxt;
  logic        was_conn_r, was_conn_nxt;
  logic [47:0] prev_ap_r, prev_ap_nxt;
  logic        prev_known_r, prev_known_nxt;
  evset_t      ev_r, ev_nxt;
  logic        ev_v_r;

  logic              adv;
  logic signed [7:0] rssi_s, good_s, weak_s;
  logic [47:0]       alert_gap, out_gap;
  logic [7:0]        weak_inc;
  logic              e_link, e_roam, e_qual;
  ev_kind_t          link_kind, qual_kind;
  logic [7:0]        qual_count;
  logic [1:0]        slot;

  assign adv       = s0_v_r && (!ev_v_r || ev_ready);
  assign smp_ready = !s0_v_r || adv;
  assign ev_valid  = ev_v_r;
  assign ev        = ev_r;

  assign rssi_s    = s0_r.rssi;
  assign good_s    = cfg.good_thr;
  assign weak_s    = cfg.weak_thr;
  assign alert_gap = s0_r.timestamp_us - last_alert_r;
  assign out_gap   = s0_r.timestamp_us - out_start_r;
  assign weak_inc  = (weak_r == 8'hFF) ? 8'hFF : weak_r + 8'd1;

  always_comb begin
    q_nxt          = q_r;
    weak_nxt       = weak_r;
    last_alert_nxt = last_alert_r;
    out_start_nxt  = out_start_r;
    was_conn_nxt   = was_conn_r;
    prev_ap_nxt    = prev_ap_r;
    prev_known_nxt = prev_known_r;
    e_link         = 1'b0;
    link_kind      = EV_DISCONNECTED;
    e_roam         = 1'b0;
    e_qual         = 1'b0;
    qual_kind      = EV_WEAK;
    qual_count     = 8'd0;
    if (!s0_r.connected) begin
      // Only the falling edge of the link is reported; quality is frozen.
      if (was_conn_r) begin
        e_link       = 1'b1;
        was_conn_nxt = 1'b0;
      end
    end else begin
      if (!was_conn_r) begin
        e_link       = 1'b1;
        link_kind    = EV_RECONNECTED;
        was_conn_nxt = 1'b1;
      end
      e_roam         = prev_known_r && (prev_ap_r != s0_r.ap_id);
      prev_ap_nxt    = s0_r.ap_id;
      prev_known_nxt = 1'b1;
      unique case (q_r)
        Q_GOOD: begin
          if (rssi_s < weak_s) begin
            q_nxt          = Q_WEAK;
            weak_nxt       = 8'd1;
            last_alert_nxt = s0_r.timestamp_us;
            e_qual         = 1'b1;
            qual_count     = 8'd1;
          end
        end
        Q_WEAK: begin
          if (rssi_s >= good_s) begin
            e_qual    = 1'b1;
            qual_kind = EV_RECOVERED;
            q_nxt     = Q_GOOD;
            weak_nxt  = 8'd0;
          end else if (alert_gap >= cfg.alert_ivl) begin
            weak_nxt       = weak_inc;
            last_alert_nxt = s0_r.timestamp_us;
            e_qual         = 1'b1;
            qual_count     = weak_inc;
            if (weak_inc >= cfg.outage_cnt) begin
              q_nxt         = Q_OUTAGE;
              out_start_nxt = s0_r.timestamp_us;
              qual_kind     = EV_OUTAGE_START;
            end
          end
        end
        Q_OUTAGE: begin
          if (rssi_s >= good_s) begin
            e_qual    = 1'b1;
            qual_kind = EV_RECOVERED_OUTAGE;
            q_nxt     = Q_GOOD;
            weak_nxt  = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Pack the events in their fixed order: link edge, roam, quality.
  always_comb begin
    ev_nxt = '0;
    slot   = 2'd0;
    if (e_link) begin
      ev_nxt.kind[slot] = link_kind;
      slot = slot + 2'd1;
    end
    if (e_roam) begin
      ev_nxt.kind[slot] = EV_ROAM;
      slot = slot + 2'd1;
    end
    if (e_qual) begin
      ev_nxt.kind[slot] = qual_kind;
      slot = slot + 2'd1;
    end
    ev_nxt.cnt      = slot;
    ev_nxt.rssi     = s0_r.rssi;
    ev_nxt.count    = qual_count;
    ev_nxt.old_id   = prev_ap_r;
    ev_nxt.new_id   = s0_r.ap_id;
    ev_nxt.dividend = out_gap[47:6];
    ev_nxt.secs     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r       <= 1'b0;
      ev_v_r       <= 1'b0;
      q_r          <= Q_GOOD;
      weak_r       <= 8'd0;
      last_alert_r <= 48'd0;
      out_start_r  <= 48'd0;
      was_conn_r   <= 1'b0;
      prev_ap_r    <= 48'd0;
      prev_known_r <= 1'b0;
    end else begin
      if (smp_valid && smp_ready) begin
        s0_v_r <= 1'b1;
      end else if (adv) begin
        s0_v_r <= 1'b0;
      end
      if (adv) begin
        ev_v_r       <= (ev_nxt.cnt != 2'd0);
        q_r          <= q_nxt;
        weak_r       <= weak_nxt;
        last_alert_r <= last_alert_nxt;
        out_start_r  <= out_start_nxt;
        was_conn_r   <= was_conn_nxt;
        prev_ap_r    <= prev_ap_nxt;
        prev_known_r <= prev_known_nxt;
      end else if (ev_ready) begin
        ev_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid && smp_ready) begin
      s0_r <= smp;
    end
    if (adv) begin
      ev_r <= ev_nxt;
    end
  end

  `LQAM_ASSERT(a_good_clear, (q_r == Q_GOOD) |-> (weak_r == 8'd0), "alert count left in good state")
  `LQAM_ASSERT(a_weak_counted, (q_r == Q_WEAK) |-> (weak_r != 8'd0), "weak state without an alert")
  `LQAM_ASSERT(a_state_hold, !adv |=> ($stable(q_r) && $stable(weak_r)), "state moved without a sample")

endmodule

`default_nettype wire

FILE: sv/lqam_div.sv
// ----------------------------------------------------------------------------
// Link quality alert monitor seconds divider
// Three-stage reciprocal multiply turning outage microseconds into seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module lqam_div import lqam_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  evset_t in_ev,
  output logic   out_valid,
  input  logic   out_ready,
  output evset_t out_ev
);

  localparam int unsigned PL_W   = DIVIDEND_W + RECIP_LO_W;
  localparam int unsigned PH_W   = DIVIDEND_W + $bits(SEC_RECIP_HI);
  localparam int unsigned PROD_W = PH_W + RECIP_LO_W;

  logic              a_v_r, b_v_r, c_v_r;
  evset_t            a_ev_r, b_ev_r, c_ev_r;
  evset_t            c_ev_nxt;
  logic [PL_W-1:0]   pl_a_r, pl_b_r;
  logic [PH_W-1:0]   ph_b_r;
  logic              a_rdy, b_rdy, c_rdy;
  logic [PROD_W-1:0] prod;

  assign c_rdy     = !c_v_r || out_ready;
  assign b_rdy     = !b_v_r || c_rdy;
  assign a_rdy     = !a_v_r || b_rdy;
  assign in_ready  = a_rdy;
  assign out_valid = c_v_r;
  assign out_ev    = c_ev_r;

  assign prod = {ph_b_r, {RECIP_LO_W{1'b0}}} + PROD_W'(pl_b_r);

  always_comb begin
    c_ev_nxt      = b_ev_r;
    c_ev_nxt.secs = prod[SEC_SHIFT +: SECS_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_ev_r <= in_ev;
      pl_a_r <= PL_W'(in_ev.dividend) * PL_W'(SEC_RECIP_LO);
    end
    if (b_rdy) begin
      b_ev_r <= a_ev_r;
      pl_b_r <= pl_a_r;
      ph_b_r <= PH_W'(a_ev_r.dividend) * PH_W'(SEC_RECIP_HI);
    end
    if (c_rdy) begin
      c_ev_r <= c_ev_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lqam_emit.sv
// ----------------------------------------------------------------------------
// Link quality alert monitor event output
// Holds one sample's event set and hands its events out one word a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lqam_emit import lqam_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  evset_t in_ev,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_ev
);

  evset_t     h_r;
  logic       hv_r;
  logic [1:0] idx_r;
  ev_kind_t   cur;
  logic       is_last;

  assign cur       = h_r.kind[idx_r];
  assign is_last   = (idx_r == h_r.cnt - 2'd1);
  assign out_valid = hv_r;
  assign in_ready  = !hv_r || (out_ready && is_last);

  always_comb begin
    out_ev.event_kind  = cur;
    out_ev.event_rssi  = (cur == EV_DISCONNECTED) ? 8'sd0 : h_r.rssi;
    out_ev.alert_count = (cur == EV_WEAK || cur == EV_OUTAGE_START) ? h_r.count : 8'd0;
    out_ev.outage_secs = (cur == EV_RECOVERED_OUTAGE) ? h_r.secs : '0;
    out_ev.old_ap_id   = (cur == EV_ROAM) ? h_r.old_id : 48'd0;
    out_ev.new_ap_id   = (cur == EV_ROAM) ? h_r.new_id : 48'd0;
    out_ev.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (in_valid && in_ready) begin
      hv_r  <= 1'b1;
      idx_r <= 2'd0;
    end else if (hv_r && out_ready) begin
      if (is_last) begin
        hv_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_r <= in_ev;
    end
  end

  `LQAM_ASSERT(a_idx_range, hv_r |-> (idx_r < h_r.cnt), "event index past the event count")
  `LQAM_ASSERT(a_idx_hold, (hv_r && !out_ready) |=> (hv_r && $stable(idx_r)), "stalled event moved on")
  `LQAM_ASSERT(a_set_nonempty, hv_r |-> (h_r.cnt != 2'd0), "empty event set held")

endmodule

`default_nettype wire

FILE: sv/link_quality_alert_monitor_core.sv
// ----------------------------------------------------------------------------
// Link quality alert monitor core
// Path: the first event word of a sample passes the input and evaluation registers,
// the three divider stages and the output holding register.
// Throughput: one sample word per cycle while each gives at most one event and
// out_tready is high; a sample with n events holds the output, one event per cycle while out_tready is high.
// Reset: synchronous on rst_n low; state returns to good, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module link_quality_alert_monitor_core import lqam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [103:0]          in_tdata,   // rssi[7:0], ap_id[55:8], timestamp_us[103:56]
  input  logic                  in_tuser,   // connected
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // event_rssi[7:0], alert_count[15:8], outage_secs[44:16], old_ap_id[92:45],
  // new_ap_id[140:93], zero fill[143:141]
  output logic [143:0]          out_tdata,
  output logic [2:0]            out_tuser,  // event_kind
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t    cfg;
  sample_t smp;
  logic    ev_valid, ev_ready, dv_valid, dv_ready;
  evset_t  ev, dv;
  event_t  oev;

  assign smp.connected    = in_tuser;
  assign smp.rssi         = in_tdata[7:0];
  assign smp.ap_id        = in_tdata[55:8];
  assign smp.timestamp_us = in_tdata[103:56];

  lqam_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lqam_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .smp_valid (in_tvalid),
    .smp_ready (in_tready),
    .smp       (smp),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev)
  );

  lqam_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ev_valid),
    .in_ready  (ev_ready),
    .in_ev     (ev),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_ev    (dv)
  );

  lqam_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_ev     (dv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ev    (oev)
  );

  assign out_tdata = {3'b000, oev.new_ap_id, oev.old_ap_id, oev.outage_secs,
                      oev.alert_count, oev.event_rssi};
  assign out_tuser = oev.event_kind;
  assign out_tlast = oev.last;

endmodule

`default_nettype wire

FILE: tb/sv/link_quality_alert_monitor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link quality alert monitor core testbench
// Sends link samples into the core with random gaps and output back-pressure.
// Every accepted sample is run through a local prediction of the connection,
// roaming and quality tracking. The expected event words are then checked,
// field by field and in order, against what the core emits. The thresholds,
// the alert interval and the outage count are rewritten between phases while
// the core is idle, extreme settings included.
// ----------------------------------------------------------------------------

module link_quality_alert_monitor_core_tb;
  import lqam_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_GOOD_THR   = 5'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WEAK_THR   = 5'd8;
  localparam logic [CFG_ADDR_W-1:0] REG_ALERT_IVL  = 5'd16;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTAGE_CNT = 5'd24;

  localparam logic [47:0] US_PER_SEC     = 48'd1000000;
  localparam logic [47:0] TIME_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {
    LQ_GOOD   = 2'd0,
    LQ_WEAK   = 2'd1,
    LQ_OUTAGE = 2'd2
  } link_quality_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [103:0]          in_tdata    = '0;   // rssi, ap_id, timestamp_us
  logic                  in_tuser    = 1'b0; // connected
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [143:0]          out_tdata;          // event_rssi, alert_count, outage_secs,
                                             // old_ap_id, new_ap_id, zero fill
  logic [2:0]            out_tuser;          // event_kind
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  link_quality_alert_monitor_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Local copy of the registers, reset values included.
  logic signed [7:0] good_thr   = GOOD_THR_RST;
  logic signed [7:0] weak_thr   = WEAK_THR_RST;
  logic [47:0]       alert_ivl  = ALERT_IVL_RST;
  logic [7:0]        outage_cnt = OUTAGE_CNT_RST;

  // Tracking state of the predicted link.
  link_quality_t quality      = LQ_GOOD;
  logic [7:0]    weak_alerts  = 8'd0;
  logic [47:0]   last_alert_us  = '0;
  logic [47:0]   outage_from_us = '0;
  logic          link_up      = 1'b0;
  logic [47:0]   prev_ap      = '0;
  logic          prev_ap_seen = 1'b0;

  sample_t     sample_queue[$];
  event_t      due_events[$];
  sample_t     next_sample;
  logic        in_taken     = 1'b0;
  logic        quiet        = 1'b0;
  int          send_gap     = 0;
  int          sink_stall   = 0;
  int          idle_cycles  = 0;
  int          error_count  = 0;
  logic [47:0] now_us       = '0;
  logic [47:0] cur_ap       = '0;
  logic [47:0] ap_pool [0:3];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- prediction

  task automatic add_event(input ev_kind_t kind, input logic signed [7:0] rssi,
                           input logic [7:0] count, input logic [SECS_W-1:0] secs,
                           input logic [47:0] old_id, input logic [47:0] new_id);
    event_t ev;
    ev.event_kind  = kind;
    ev.event_rssi  = rssi;
    ev.alert_count = count;
    ev.outage_secs = secs;
    ev.old_ap_id   = old_id;
    ev.new_ap_id   = new_id;
    ev.last        = 1'b0;
    due_events.push_back(ev);
  endtask

  task automatic predict_sample_events(input sample_t s);
    int          queued_at_start;
    logic [47:0] elapsed;
    queued_at_start = due_events.size();
    if (!s.connected) begin
      if (link_up) begin
        add_event(EV_DISCONNECTED, 8'sd0, 8'd0, '0, '0, '0);
        link_up = 1'b0;
      end
    end else begin
      if (!link_up) begin
        add_event(EV_RECONNECTED, s.rssi, 8'd0, '0, '0, '0);
        link_up = 1'b1;
      end
      if (prev_ap_seen && prev_ap != s.ap_id)
        add_event(EV_ROAM, s.rssi, 8'd0, '0, prev_ap, s.ap_id);
      prev_ap      = s.ap_id;
      prev_ap_seen = 1'b1;

      case (quality)
        LQ_GOOD: begin
          if (s.rssi < weak_thr) begin
            quality       = LQ_WEAK;
            weak_alerts   = 8'd1;
            last_alert_us = s.timestamp_us;
            add_event(EV_WEAK, s.rssi, weak_alerts, '0, '0, '0);
          end
        end
        LQ_WEAK: begin
          elapsed = s.timestamp_us - last_alert_us;
          if (s.rssi >= good_thr) begin
            add_event(EV_RECOVERED, s.rssi, 8'd0, '0, '0, '0);
            quality     = LQ_GOOD;
            weak_alerts = 8'd0;
          end else if (elapsed >= alert_ivl) begin
            if (weak_alerts != 8'd255)
              weak_alerts = weak_alerts + 8'd1;
            last_alert_us = s.timestamp_us;
            if (weak_alerts >= outage_cnt) begin
              quality        = LQ_OUTAGE;
              outage_from_us = s.timestamp_us;
              add_event(EV_OUTAGE_START, s.rssi, weak_alerts, '0, '0, '0);
            end else begin
              add_event(EV_WEAK, s.rssi, weak_alerts, '0, '0, '0);
            end
          end
        end
        LQ_OUTAGE: begin
          if (s.rssi >= good_thr) begin
            elapsed = (s.timestamp_us - outage_from_us) / US_PER_SEC;
            add_event(EV_RECOVERED_OUTAGE, s.rssi, 8'd0, elapsed[SECS_W-1:0], '0, '0);
            quality     = LQ_GOOD;
            weak_alerts = 8'd0;
          end
        end
        default: ;
      endcase
    end
    if (due_events.size() > queued_at_start)
      due_events[due_events.size() - 1].last = 1'b1;
  endtask

  // ------------------------------------------------------------------ checking

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_event_word();
    event_t want;
    if (due_events.size() == 0) begin
      $error("event word with kind %0d arrived when none was expected", out_tuser);
      error_count++;
    end else begin
      want = due_events.pop_front();
      compare_field("event_kind", 64'(want.event_kind), 64'(out_tuser));
      compare_field("event_rssi", 64'(want.event_rssi[7:0]), 64'(out_tdata[7:0]));
      compare_field("alert_count", 64'(want.alert_count), 64'(out_tdata[15:8]));
      compare_field("outage_secs", 64'(want.outage_secs), 64'(out_tdata[44:16]));
      compare_field("old_ap_id", 64'(want.old_ap_id), 64'(out_tdata[92:45]));
      compare_field("new_ap_id", 64'(want.new_ap_id), 64'(out_tdata[140:93]));
      compare_field("last", 64'(want.last), 64'(out_tlast));
    end
  endtask

  // -------------------------------------------------------- driver and monitor

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (send_gap > 0 || sample_queue.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap > 0)
          send_gap <= send_gap - 1;
      end else begin
        next_sample = sample_queue.pop_front();
        in_tdata  <= {next_sample.timestamp_us, next_sample.ap_id, next_sample.rssi};
        in_tuser  <= next_sample.connected;
        in_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0)
          send_gap <= $urandom_range(1, 10);
      end
    end
  end

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0)
        sink_stall <= $urandom_range(1, 10);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        predict_sample_events({in_tuser, in_tdata[7:0], in_tdata[55:8], in_tdata[103:56]});
      if (out_tvalid && out_tready)
        check_event_word();
    end
  end

  // A stuck core shows up as a long run of cycles in which no word moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ------------------------------------------------------------------ stimulus

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic signed [7:0] pick_rssi();
    int v;
    case ($urandom_range(0, 4))
      0: begin
        v = good_thr;
        v = v + int'($urandom_range(0, 4)) - 2;
      end
      1: begin
        v = weak_thr;
        v = v + int'($urandom_range(0, 4)) - 2;
      end
      2: v = ($urandom_range(0, 1) == 1) ? 127 : -128;
      default: v = int'($urandom_range(0, 255)) - 128;
    endcase
    if (v > 127)
      v = 127;
    if (v < -128)
      v = -128;
    return 8'(v);
  endfunction

  task automatic queue_sample(input logic conn, input logic signed [7:0] rssi,
                              input logic [47:0] ap, input logic [47:0] ts);
    sample_t s;
    s.connected    = conn;
    s.rssi         = rssi;
    s.ap_id        = ap;
    s.timestamp_us = ts;
    sample_queue.push_back(s);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      REG_GOOD_THR:   good_thr   = value[7:0];
      REG_WEAK_THR:   weak_thr   = value[7:0];
      REG_ALERT_IVL:  alert_ivl  = value[47:0];
      REG_OUTAGE_CNT: outage_cnt = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic signed [7:0] good, input logic signed [7:0] weak_lvl,
                                input logic [47:0] ivl, input logic [7:0] cnt);
    write_register(REG_GOOD_THR, 64'(good[7:0]));
    write_register(REG_WEAK_THR, 64'(weak_lvl[7:0]));
    write_register(REG_ALERT_IVL, 64'(ivl));
    write_register(REG_OUTAGE_CNT, 64'(cnt));
  endtask

  // Let everything queued go through and every event word come back, then
  // allow for samples that gave no event but may still be in the pipeline.
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_tvalid || due_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly connected sessions on a few access points with time stepping
  // around the alert interval; now and then a wholly random sample.
  task automatic queue_link_traffic(input int count);
    logic [47:0] step;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        now_us = rand48();
        queue_sample(1'($urandom_range(0, 1)), 8'($urandom), rand48(), now_us);
      end else begin
        case ($urandom_range(0, 3))
          0: step = 48'($urandom_range(0, 2000));
          1: step = alert_ivl;
          2: step = alert_ivl + 48'($urandom_range(0, 3000000));
          default: step = alert_ivl - 48'($urandom_range(0, 2000));
        endcase
        now_us = now_us + step;
        if ($urandom_range(0, 7) == 0)
          cur_ap = ap_pool[2'($urandom_range(0, 3))];
        queue_sample($urandom_range(0, 11) != 0, pick_rssi(), cur_ap, now_us);
      end
    end
  endtask

  initial begin
    ap_pool[0] = '0;
    ap_pool[1] = TIME_MAX;
    ap_pool[2] = 48'h0024_D7A1_3C5E;
    ap_pool[3] = rand48();
    cur_ap     = ap_pool[2];

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings. A lost link before any
    // connection gives nothing, and the first connection cannot roam.
    queue_sample(1'b0, 8'sd127, TIME_MAX, TIME_MAX);
    queue_sample(1'b1, -8'sd128, 48'd0, 48'd0);
    queue_sample(1'b1, -8'sd80, 48'd0, 48'd5000000);
    queue_sample(1'b1, -8'sd80, 48'd1, 48'd10000000);
    queue_sample(1'b1, -8'sd90, 48'd1, 48'd20000000);
    queue_sample(1'b0, -8'sd90, 48'd7, 48'd21000000);
    queue_sample(1'b0, 8'sd0, 48'd7, 48'd22000000);
    // Reconnect, roam and recovery from the outage all in one sample.
    queue_sample(1'b1, 8'sd127, TIME_MAX, TIME_MAX);
    queue_sample(1'b1, -8'sd75, TIME_MAX, 48'd100);
    queue_sample(1'b1, -8'sd76, TIME_MAX, 48'd200);
    queue_sample(1'b1, -8'sd61, TIME_MAX, 48'd300);
    queue_sample(1'b1, -8'sd60, TIME_MAX, 48'd400);
    // A weak phase that starts just before the time counter wraps, then an outage after it.
    now_us = 48'hFFFF_FFF0_0000;
    queue_sample(1'b1, -8'sd128, 48'd5, now_us);
    now_us = now_us + 48'd10000000;
    queue_sample(1'b1, -8'sd100, 48'd5, now_us);
    now_us = now_us + 48'd10000000;
    queue_sample(1'b1, -8'sd100, 48'd5, now_us);
    now_us = now_us + 48'd3500000;
    queue_sample(1'b1, 8'sd0, 48'd5, now_us);
    queue_link_traffic(40);
    wait_drained();

    apply_settings(-8'sd128, 8'sd127, 48'd0, 8'd1);
    queue_link_traffic(50);
    wait_drained();

    apply_settings(8'sd127, 8'sd127, TIME_MAX, 8'd255);
    queue_link_traffic(40);
    wait_drained();

    // An outage count of zero acts like one.
    apply_settings(-8'sd60, -8'sd75, 48'd1000, 8'd0);
    queue_link_traffic(50);
    wait_drained();

    apply_settings(8'($urandom), 8'($urandom), 48'($urandom_range(0, 3000000)),
                   8'($urandom_range(1, 6)));
    queue_link_traffic(50);
    wait_drained();

    quiet = 1'b1;
    apply_settings(-8'sd70, -8'sd80, 48'd500000, 8'd2);
    queue_link_traffic(50);
    wait_drained();

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
